// File: rtl/core/fprm_pkg.sv
// shared types and constants for the fragment playback ring manager
package fprm_pkg;

    localparam int FRAG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int EV_W      = 4;
    localparam int DSLOT_W   = 1;
    localparam int BSLOT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES   = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_IRQ   = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_STARTED    = 4'd0,
        EV_DMA_FILLED = 4'd1,
        EV_OVF_FILLED = 4'd2,
        EV_MISMATCH   = 4'd3,
        EV_RETRY      = 4'd4,
        EV_IDLE       = 4'd5,
        EV_HALTED     = 4'd6,
        EV_MOVED      = 4'd7,
        EV_CONTINUE   = 4'd8
    } event_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } state_t;

    // datapath flags the controller decides on
    typedef struct packed {
        logic size_match;
        logic active;
        logic dma_room;
        logic ovf_valid;
        logic ovf_full;
        logic halt_next;
    } status_t;

    typedef struct packed {
        logic   take;
        event_t ev;
    } ctl_t;

endpackage

// File: rtl/core/fprm_ctrl.sv
// controller: handshake state machine and event decision
module fprm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    input  logic              out_stall,
    input  fprm_pkg::status_t status,
    output fprm_pkg::ctl_t    ctl,
    output logic              in_stall,
    output logic              out_valid
);

    fprm_pkg::state_t state_reg;
    fprm_pkg::state_t state_next;
    fprm_pkg::event_t ev;
    logic             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fprm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // event decision from the current bookkeeping
    always_comb
    begin
        if (command == fprm_pkg::CMD_WRITE)
        begin
            if (!status.size_match)
                ev = fprm_pkg::EV_MISMATCH;
            else if (!status.active)
                ev = fprm_pkg::EV_STARTED;
            else if (status.dma_room)
                ev = fprm_pkg::EV_DMA_FILLED;
            else if (!status.ovf_valid)
                ev = fprm_pkg::EV_OVF_FILLED;
            else if (status.ovf_full)
                ev = fprm_pkg::EV_RETRY;
            else
                ev = fprm_pkg::EV_OVF_FILLED;
        end
        else
        begin
            if (!status.active)
                ev = fprm_pkg::EV_IDLE;
            else if (status.halt_next)
                ev = fprm_pkg::EV_HALTED;
            else if (status.ovf_valid)
                ev = fprm_pkg::EV_MOVED;
            else
                ev = fprm_pkg::EV_CONTINUE;
        end
    end

    assign take = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fprm_pkg::ST_IDLE:
            begin
                if (take)
                    state_next = fprm_pkg::ST_HOLD;
            end
            fprm_pkg::ST_HOLD:
            begin
                // result beat leaves; a new beat may come in the same cycle
                if (!out_stall && !take)
                    state_next = fprm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fprm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            fprm_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                out_valid = 1'b0;
            end
            fprm_pkg::ST_HOLD:
            begin
                in_stall  = out_stall;
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall  = 1'b1;
                out_valid = 1'b0;
            end
        endcase
    end

    assign ctl.take = take;
    assign ctl.ev   = ev;

endmodule

// File: rtl/core/fprm_datapath.sv
// datapath: configuration, slot pointers and result register
module fprm_datapath #(
    parameter int DMA_SLOTS          = 2,
    parameter int OVERFLOW_SLOTS     = 8,
    parameter int MAX_FRAGMENT_BYTES = 32768
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fprm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fprm_pkg::CFG_W-1:0]          cfg_data,
    input  logic [fprm_pkg::FRAG_W-1:0]         byte_count,
    input  fprm_pkg::ctl_t                      ctl,
    output fprm_pkg::status_t                   status,
    output logic [fprm_pkg::EV_W-1:0]           event_code,
    output logic [fprm_pkg::DSLOT_W-1:0]        dma_slot,
    output logic [fprm_pkg::BSLOT_W-1:0]        buffer_slot,
    output logic                                halt_wide,
    output logic                                playing
);

    localparam int DMA_W = (DMA_SLOTS > 1) ? $clog2(DMA_SLOTS) : 1;
    localparam int OVF_W = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;
    localparam logic [DMA_W-1:0] DMA_LAST = DMA_W'(DMA_SLOTS - 1);
    localparam logic [OVF_W-1:0] OVF_LAST = OVF_W'(OVERFLOW_SLOTS - 1);
    localparam logic [fprm_pkg::FRAG_W-1:0] FRAG_RESET =
        fprm_pkg::FRAG_W'(MAX_FRAGMENT_BYTES);

    logic [fprm_pkg::FRAG_W-1:0]  frag_reg;
    logic                         wide_reg;
    logic                         active_reg;
    logic [DMA_W-1:0]             play_reg;
    logic [DMA_W-1:0]             fill_reg;
    logic                         ovf_valid_reg;
    logic [OVF_W-1:0]             rd_reg;
    logic [OVF_W-1:0]             wr_reg;

    logic                         active_next;
    logic [DMA_W-1:0]             play_next;
    logic [DMA_W-1:0]             fill_next;
    logic                         ovf_valid_next;
    logic [OVF_W-1:0]             rd_next;
    logic [OVF_W-1:0]             wr_next;

    logic [fprm_pkg::EV_W-1:0]    event_reg;
    logic [DMA_W-1:0]             dslot_reg;
    logic [OVF_W-1:0]             bslot_reg;
    logic                         hw_reg;
    logic [DMA_W-1:0]             dslot_next;
    logic [OVF_W-1:0]             bslot_next;
    logic                         hw_next;

    logic [DMA_W-1:0]             play_inc;
    logic [DMA_W-1:0]             fill_inc;
    logic [OVF_W-1:0]             rd_inc;
    logic [OVF_W-1:0]             wr_inc;
    logic [OVF_W+fprm_pkg::BSLOT_W-1:0] bslot_ext;

    function automatic logic [DMA_W-1:0] next_dma(input logic [DMA_W-1:0] s);
        next_dma = (s == DMA_LAST) ? '0 : s + DMA_W'(1);
    endfunction

    function automatic logic [OVF_W-1:0] next_ovf(input logic [OVF_W-1:0] s);
        next_ovf = (s == OVF_LAST) ? '0 : s + OVF_W'(1);
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_reg <= FRAG_RESET;
            wide_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == fprm_pkg::REG_FRAGMENT_BYTES)
                frag_reg <= cfg_data;
            else if (cfg_index == fprm_pkg::REG_WIDE_SAMPLES)
                wide_reg <= cfg_data[0];
        end
    end

    assign play_inc = next_dma(play_reg);
    assign fill_inc = next_dma(fill_reg);
    assign rd_inc   = next_ovf(rd_reg);
    assign wr_inc   = next_ovf(wr_reg);

    assign status.size_match = (byte_count == frag_reg);
    assign status.active     = active_reg;
    assign status.dma_room   = (play_reg != fill_reg);
    assign status.ovf_valid  = ovf_valid_reg;
    assign status.ovf_full   = (rd_reg == wr_reg);
    assign status.halt_next  = (play_inc == fill_reg);

    always_comb
    begin
        active_next    = active_reg;
        play_next      = play_reg;
        fill_next      = fill_reg;
        ovf_valid_next = ovf_valid_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        dslot_next     = '0;
        bslot_next     = '0;
        hw_next        = 1'b0;
        case (ctl.ev)
            fprm_pkg::EV_STARTED:
            begin
                active_next = 1'b1;
                play_next   = '0;
                fill_next   = next_dma('0);
            end
            fprm_pkg::EV_DMA_FILLED:
            begin
                dslot_next = fill_reg;
                fill_next  = fill_inc;
            end
            fprm_pkg::EV_OVF_FILLED:
            begin
                // an empty overflow ring always restarts at slot 0
                if (!ovf_valid_reg)
                begin
                    ovf_valid_next = 1'b1;
                    rd_next        = '0;
                    wr_next        = next_ovf('0);
                end
                else
                begin
                    bslot_next = wr_reg;
                    wr_next    = wr_inc;
                end
            end
            fprm_pkg::EV_HALTED:
            begin
                play_next   = play_inc;
                active_next = 1'b0;
                hw_next     = wide_reg;
            end
            fprm_pkg::EV_MOVED:
            begin
                play_next  = play_inc;
                dslot_next = fill_reg;
                bslot_next = rd_reg;
                rd_next    = rd_inc;
                fill_next  = fill_inc;
                if (rd_inc == wr_reg)
                    ovf_valid_next = 1'b0;
            end
            fprm_pkg::EV_CONTINUE:
            begin
                play_next = play_inc;
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            play_reg      <= '0;
            fill_reg      <= '0;
            ovf_valid_reg <= 1'b0;
            rd_reg        <= '0;
            wr_reg        <= '0;
        end
        else if (ctl.take)
        begin
            active_reg    <= active_next;
            play_reg      <= play_next;
            fill_reg      <= fill_next;
            ovf_valid_reg <= ovf_valid_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
        end
    end

    // result beat, held until taken
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            event_reg <= ctl.ev;
            dslot_reg <= dslot_next;
            bslot_reg <= bslot_next;
            hw_reg    <= hw_next;
        end
    end

    assign bslot_ext   = {{fprm_pkg::BSLOT_W{1'b0}}, bslot_reg};
    assign event_code  = event_reg;
    assign dma_slot    = dslot_reg[fprm_pkg::DSLOT_W-1:0];
    assign buffer_slot = bslot_ext[fprm_pkg::BSLOT_W-1:0];
    assign halt_wide   = hw_reg;
    assign playing     = active_reg;

    a_start_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && ctl.ev == fprm_pkg::EV_STARTED |=> active_reg && play_reg == '0)
        else $error("start did not rewind play slot");

    a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && ctl.ev == fprm_pkg::EV_HALTED |=> !active_reg)
        else $error("halt left playback active");

    a_retry_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && ctl.ev == fprm_pkg::EV_RETRY |=>
            $stable(wr_reg) && $stable(rd_reg) && $stable(fill_reg) && $stable(play_reg))
        else $error("retry changed slot pointers");

    a_move_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && ctl.ev == fprm_pkg::EV_MOVED |-> ovf_valid_reg && active_reg)
        else $error("move without overflow data");

endmodule

// File: rtl/core/fragment_playback_ring_manager_unit.sv
// Fragment playback ring manager: slot bookkeeping for a DMA ring and an
// overflow ring of audio fragments. Each input beat (a fragment write or a
// completion interrupt) yields exactly one result beat. The bookkeeping
// updates in the cycle a beat is accepted and the result sits in an output
// register; a new beat is taken in the same cycle the previous result leaves,
// so the block sustains one beat per cycle when the result side does not
// stall; results appear the cycle after acceptance. Configuration writes
// go straight to their registers and should only be made while idle.
module fragment_playback_ring_manager_unit #(
    parameter int DMA_SLOTS          = 2,
    parameter int OVERFLOW_SLOTS     = 8,
    parameter int MAX_FRAGMENT_BYTES = 32768
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fprm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fprm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [fprm_pkg::FRAG_W-1:0]         byte_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fprm_pkg::EV_W-1:0]           event_code,
    output logic [fprm_pkg::DSLOT_W-1:0]        dma_slot,
    output logic [fprm_pkg::BSLOT_W-1:0]        buffer_slot,
    output logic                                halt_wide,
    output logic                                playing
);

    fprm_pkg::status_t status;
    fprm_pkg::ctl_t    ctl;

    fprm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .status    (status),
        .ctl       (ctl),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    fprm_datapath #(
        .DMA_SLOTS          (DMA_SLOTS),
        .OVERFLOW_SLOTS     (OVERFLOW_SLOTS),
        .MAX_FRAGMENT_BYTES (MAX_FRAGMENT_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_count  (byte_count),
        .ctl         (ctl),
        .status      (status),
        .event_code  (event_code),
        .dma_slot    (dma_slot),
        .buffer_slot (buffer_slot),
        .halt_wide   (halt_wide),
        .playing     (playing)
    );

endmodule
